// File: src/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types, widths and codes shared by the point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = (PROD_W + 1 > 64) ? 64 : PROD_W + 1;
    localparam int ROOT_W     = (SQ_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int OUT_W      = 26;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_X = 2'd0,
        REG_START_Y = 2'd1,
        REG_END_X   = 2'd2,
        REG_END_Y   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        REGION_BEFORE = 2'd0,
        REGION_WITHIN = 2'd1,
        REGION_BEYOND = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } query_t;

    typedef struct packed {
        logic [OUT_W-1:0] dist_to_segment;
        logic [OUT_W-1:0] along_length;
        logic [1:0]       region;
        logic             degenerate;
    } result_t;

    typedef struct packed {
        logic [SQ_W-1:0] ab2;
        logic [SQ_W-1:0] ap2;
        logic [SQ_W-1:0] bp2;
        logic [SQ_W-1:0] dmag;
        logic            neg;
        logic            degen;
    } qentry_t;

    localparam logic [ROOT_W:0] OUT_MAX_R = (ROOT_W + 1)'((64'd1 << OUT_W) - 64'd1);

    function automatic logic [OUT_W-1:0] sat_out(input logic [ROOT_W-1:0] v);
        logic [OUT_W-1:0] r;
        if ({1'b0, v} > OUT_MAX_R)
            r = OUT_W'(OUT_MAX_R);
        else
            r = OUT_W'(v);
        return r;
    endfunction

endpackage

// File: src/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined floor integer square root, one result bit per stage, with a
// sideband carried alongside each request.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [psd_pkg::RAD_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [psd_pkg::ROOT_W-1:0]  root,
    output logic [SIDE_W-1:0]           out_side
);

    localparam int RW    = psd_pkg::ROOT_W;
    localparam int NW    = psd_pkg::RAD_W;
    localparam int REM_W = RW + 2;

    logic [REM_W-1:0]  rem_reg  [0:RW];
    logic [RW-1:0]     root_reg [0:RW];
    logic [NW-1:0]     n_reg    [0:RW];
    logic [SIDE_W-1:0] side_reg [0:RW];
    logic              vld_reg  [0:RW];

    logic [REM_W-1:0]  rem_next  [0:RW-1];
    logic [RW-1:0]     root_next [0:RW-1];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        always_comb
        begin
            rem_sh = {rem_reg[i][REM_W-3:0], n_reg[i][NW-1 -: 2]};
            trial  = {root_reg[i], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next[i]  = rem_sh - trial;
                root_next[i] = {root_reg[i][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = rem_sh;
                root_next[i] = {root_reg[i][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        n_reg[0]    <= radicand;
        side_reg[0] <= in_side;
        for (int i = 0; i < RW; i++)
        begin
            rem_reg[i+1]  <= rem_next[i];
            root_reg[i+1] <= root_next[i];
            n_reg[i+1]    <= n_reg[i] << 2;
            side_reg[i+1] <= side_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= RW; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 0; i < RW; i++)
                vld_reg[i+1] <= vld_reg[i];
        end
    end

    assign out_valid = vld_reg[RW];
    assign root      = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

// File: src/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Segment registers and request intake: forms the coordinate differences,
// the squared lengths and the signed projection dot product.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  psd_pkg::query_t                 query,
    input  logic                            wr_en,
    input  logic [psd_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [psd_pkg::COORD_BITS-1:0]  wr_data,
    output logic                            push,
    output psd_pkg::qentry_t                entry
);

    localparam int CW = psd_pkg::COORD_BITS;
    localparam int DW = psd_pkg::DIFF_W;
    localparam int PW = psd_pkg::PROD_W;
    localparam int SW = psd_pkg::SQ_W;

    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    logic signed [DW-1:0] abx_reg, aby_reg, apx_reg, apy_reg, bpx_reg, bpy_reg;
    logic                 degen1_reg, v1_reg;

    logic signed [PW-1:0] abx2_reg, aby2_reg, apx2_reg, apy2_reg, bpx2_reg, bpy2_reg;
    logic signed [PW-1:0] dx_reg, dy_reg;
    logic                 degen2_reg, v2_reg;

    logic [SW-1:0] dot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            ex_reg <= '0;
            ey_reg <= '0;
        end
        else if (wr_en)
        begin
            case (psd_pkg::reg_index_t'(wr_index))
                psd_pkg::REG_START_X: sx_reg <= wr_data;
                psd_pkg::REG_START_Y: sy_reg <= wr_data;
                psd_pkg::REG_END_X:   ex_reg <= wr_data;
                psd_pkg::REG_END_Y:   ey_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abx_reg    <= DW'(ex_reg) - DW'(sx_reg);
        aby_reg    <= DW'(ey_reg) - DW'(sy_reg);
        apx_reg    <= DW'(query.query_x) - DW'(sx_reg);
        apy_reg    <= DW'(query.query_y) - DW'(sy_reg);
        bpx_reg    <= DW'(query.query_x) - DW'(ex_reg);
        bpy_reg    <= DW'(query.query_y) - DW'(ey_reg);
        degen1_reg <= (ex_reg == sx_reg) && (ey_reg == sy_reg);

        abx2_reg   <= abx_reg * abx_reg;
        aby2_reg   <= aby_reg * aby_reg;
        apx2_reg   <= apx_reg * apx_reg;
        apy2_reg   <= apy_reg * apy_reg;
        bpx2_reg   <= bpx_reg * bpx_reg;
        bpy2_reg   <= bpy_reg * bpy_reg;
        dx_reg     <= abx_reg * apx_reg;
        dy_reg     <= aby_reg * apy_reg;
        degen2_reg <= degen1_reg;
    end

    always_comb
    begin
        dot         = SW'(dx_reg) + SW'(dy_reg);
        entry.ab2   = SW'(abx2_reg) + SW'(aby2_reg);
        entry.ap2   = SW'(apx2_reg) + SW'(apy2_reg);
        entry.bp2   = SW'(bpx2_reg) + SW'(bpy2_reg);
        entry.neg   = dot[SW-1];
        entry.dmag  = dot[SW-1] ? (SW'(0) - dot) : dot;
        entry.degen = degen2_reg;
    end

    assign push = v2_reg;

endmodule

// File: src/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module psd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psd_pkg::qentry_t  in_entry,
    output logic              full,
    output logic              out_valid,
    output psd_pkg::qentry_t  out_entry
);

    psd_pkg::qentry_t mem_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             pop;

    assign pop       = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_valid = pop;
    assign out_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("request pushed into a full queue");

endmodule

// File: src/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Segment length root, projection divide, region decision and distance root.
// ----------------------------------------------------------------------------
module psd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  psd_pkg::qentry_t  in_entry,
    output logic              done,
    output psd_pkg::result_t  result
);

    localparam int RW = psd_pkg::ROOT_W;
    localparam int NW = psd_pkg::RAD_W;
    localparam int SW = psd_pkg::SQ_W;

    typedef struct packed {
        logic [SW-1:0] dmag;
        logic          neg;
        logic [SW-1:0] ap2;
        logic [SW-1:0] bp2;
        logic          degen;
    } len_side_t;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [SW-1:0] ap2;
        logic [SW-1:0] bp2;
        logic          degen;
    } div_side_t;

    typedef struct packed {
        logic [RW-1:0] along;
        logic [1:0]    region;
        logic          degen;
    } dist_side_t;

    typedef enum logic [1:0] {
        SEL_AP,
        SEL_BP,
        SEL_PERP
    } sel_t;

    localparam int LS_W = $bits(len_side_t);
    localparam int DS_W = $bits(dist_side_t);

    // segment length
    len_side_t     ls_in, ls_out;
    logic [LS_W-1:0] ls_out_bits;
    logic          ab_valid;
    logic [RW-1:0] ab;

    always_comb
    begin
        ls_in.dmag  = in_entry.dmag;
        ls_in.neg   = in_entry.neg;
        ls_in.ap2   = in_entry.ap2;
        ls_in.bp2   = in_entry.bp2;
        ls_in.degen = in_entry.degen;
    end

    psd_sqrt #(.SIDE_W(LS_W)) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .radicand  (NW'(in_entry.ab2)),
        .in_side   (ls_in),
        .out_valid (ab_valid),
        .root      (ab),
        .out_side  (ls_out_bits)
    );

    assign ls_out = len_side_t'(ls_out_bits);

    // projection divide
    logic [RW-1:0] dr_reg  [0:RW];
    logic [RW-1:0] dl_reg  [0:RW];
    logic [RW-1:0] dq_reg  [0:RW];
    logic [RW-1:0] dab_reg [0:RW];
    div_side_t     ds_reg  [0:RW];
    logic          dv_reg  [0:RW];

    logic [RW-1:0] dr_next [0:RW-1];
    logic [RW-1:0] dq_next [0:RW-1];

    for (genvar j = 0; j < RW; j++) begin : g_div
        logic [RW:0] t;
        logic        ge;
        always_comb
        begin
            t          = {dr_reg[j], dl_reg[j][RW-1]};
            ge         = (t >= {1'b0, dab_reg[j]});
            dr_next[j] = ge ? RW'(t - {1'b0, dab_reg[j]}) : t[RW-1:0];
            dq_next[j] = {dq_reg[j][RW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg[0]     <= RW'(ls_out.dmag >> RW);
        dl_reg[0]     <= ls_out.dmag[RW-1:0];
        dq_reg[0]     <= '0;
        dab_reg[0]    <= ab;
        ds_reg[0].neg   <= ls_out.neg;
        ds_reg[0].ovf   <= (ls_out.dmag >> RW) >= SW'(ab);
        ds_reg[0].ap2   <= ls_out.ap2;
        ds_reg[0].bp2   <= ls_out.bp2;
        ds_reg[0].degen <= ls_out.degen;
        for (int j = 0; j < RW; j++)
        begin
            dr_reg[j+1]  <= dr_next[j];
            dl_reg[j+1]  <= dl_reg[j] << 1;
            dq_reg[j+1]  <= dq_next[j];
            dab_reg[j+1] <= dab_reg[j];
            ds_reg[j+1]  <= ds_reg[j];
        end
    end

    // region decision
    div_side_t     dso;
    logic [RW-1:0] q, abd;
    sel_t          sel_c;
    logic [RW-1:0] along_c;
    logic [1:0]    region_c;

    assign dso = ds_reg[RW];
    assign q   = dq_reg[RW];
    assign abd = dab_reg[RW];

    always_comb
    begin
        if (dso.degen || abd == '0)
        begin
            sel_c    = SEL_AP;
            along_c  = '0;
            region_c = psd_pkg::REGION_BEFORE;
        end
        else if (dso.neg && (dso.ovf || q != '0))
        begin
            sel_c    = SEL_AP;
            along_c  = '0;
            region_c = psd_pkg::REGION_BEFORE;
        end
        else if (!dso.neg && (dso.ovf || q >= abd))
        begin
            sel_c    = SEL_BP;
            along_c  = abd;
            region_c = psd_pkg::REGION_BEYOND;
        end
        else
        begin
            sel_c    = SEL_PERP;
            along_c  = dso.neg ? '0 : q;
            region_c = psd_pkg::REGION_WITHIN;
        end
    end

    logic [NW-1:0] qq_reg;
    logic [SW-1:0] ap2_reg, bp2_reg;
    sel_t          sel_reg;
    dist_side_t    mside_reg;
    logic          mv_reg;

    always_ff @(posedge clk)
    begin
        qq_reg           <= NW'(q) * NW'(q);
        ap2_reg          <= dso.ap2;
        bp2_reg          <= dso.bp2;
        sel_reg          <= sel_c;
        mside_reg.along  <= along_c;
        mside_reg.region <= region_c;
        mside_reg.degen  <= dso.degen;
    end

    // distance root
    logic [NW-1:0] rad;

    always_comb
    begin
        case (sel_reg)
            SEL_AP:   rad = NW'(ap2_reg);
            SEL_BP:   rad = NW'(bp2_reg);
            SEL_PERP: rad = (NW'(ap2_reg) > qq_reg) ? (NW'(ap2_reg) - qq_reg) : '0;
            default:  rad = '0;
        endcase
    end

    logic            dist_valid;
    logic [RW-1:0]   dist_root;
    logic [DS_W-1:0] dside_bits;
    dist_side_t      dside;

    psd_sqrt #(.SIDE_W(DS_W)) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mv_reg),
        .radicand  (rad),
        .in_side   (mside_reg),
        .out_valid (dist_valid),
        .root      (dist_root),
        .out_side  (dside_bits)
    );

    assign dside = dist_side_t'(dside_bits);

    logic              done_reg;
    psd_pkg::result_t  result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
            for (int j = 0; j < RW; j++)
                dv_reg[j+1] <= 1'b0;
            mv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= ab_valid;
            for (int j = 0; j < RW; j++)
                dv_reg[j+1] <= dv_reg[j];
            mv_reg   <= dv_reg[RW];
            done_reg <= dist_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.dist_to_segment <= psd_pkg::sat_out(dist_root);
        result_reg.along_length    <= psd_pkg::sat_out(dside.along);
        result_reg.region          <= dside.region;
        result_reg.degenerate      <= dside.degen;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: src/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to the configured segment, with the clamped
// projection, a region code and a zero-length flag.
// ----------------------------------------------------------------------------
// A request is taken on every cycle where start is high and busy is low; a
// new query may follow each clock. Each request returns one result, strobed
// by done for a single cycle, once it has passed through three 26-stage
// units in series: the segment length root, the projection divider and the
// distance root. The receiver cannot stall the results, so busy stays low
// in operation. Write the segment registers only while no request is in
// flight.
module point_segment_distance (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  psd_pkg::query_t                 query,
    output logic                            done,
    output psd_pkg::result_t                result,
    input  logic                            wr_en,
    input  logic [psd_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [psd_pkg::COORD_BITS-1:0]  wr_data
);

    logic              push;
    psd_pkg::qentry_t  f_entry;
    logic              q_valid;
    psd_pkg::qentry_t  q_entry;

    psd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .query    (query),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .entry    (f_entry)
    );

    psd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_entry  (f_entry),
        .full      (busy),
        .out_valid (q_valid),
        .out_entry (q_entry)
    );

    psd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_entry (q_entry),
        .done     (done),
        .result   (result)
    );

    a_degen_before: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |->
            result.region == psd_pkg::REGION_BEFORE && result.along_length == '0)
        else $error("degenerate segment result not at start");

    a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.region == psd_pkg::REGION_BEFORE |-> result.along_length == '0)
        else $error("projection nonzero before start");

    a_beyond_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.region == psd_pkg::REGION_BEYOND |-> !result.degenerate)
        else $error("degenerate segment reported beyond end");

endmodule
